// ----- src/ata_pkg.sv -----
// ----------------------------------------------------------------------------
// ata_pkg: shared constants for the tilt angle unit
// Widths, stage counts and the CORDIC arctangent table in Q16 degrees.
// ----------------------------------------------------------------------------
package ata_pkg;

    localparam int SAMPLE_BITS   = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int FRAC_BITS     = 16;
    localparam int DEG_BITS      = 8;
    localparam int HALF_TURN     = 180;

    // input word: three samples, padded to whole bytes
    localparam int IN_BITS       = 3 * SAMPLE_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    // squares sum: 2*(2^(S-1))^2 = 2^(2S-1), needs 2S bits
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    // radicand = sq << 32
    localparam int RAD_BITS  = SQ_BITS + 32;
    localparam int ROOT_BITS = RAD_BITS / 2;
    // CORDIC datapath: root grows by gain 1.65, numerator 2^(S-1+16)
    localparam int CW        = ROOT_BITS + 3;
    localparam int ZW        = 26;

    localparam logic signed [DEG_BITS-1:0] DEG_MAX = DEG_BITS'(HALF_TURN / 2);
    localparam logic signed [DEG_BITS-1:0] DEG_MIN = -DEG_BITS'(HALF_TURN / 2);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DEG_BITS-1:0]    deg_t;

    typedef enum logic [1:0] {
        SPEC_NONE = 2'd0,
        SPEC_POS  = 2'd1,
        SPEC_NEG  = 2'd2,
        SPEC_ZERO = 2'd3
    } spec_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] t;
        unique case (i)
            0: t = 26'sd2949120;   1: t = 26'sd1740967;   2: t = 26'sd919879;
            3: t = 26'sd466945;    4: t = 26'sd234379;    5: t = 26'sd117304;
            6: t = 26'sd58666;     7: t = 26'sd29335;     8: t = 26'sd14668;
            9: t = 26'sd7334;      10: t = 26'sd3667;     11: t = 26'sd1833;
            12: t = 26'sd917;      13: t = 26'sd458;      14: t = 26'sd229;
            15: t = 26'sd115;      16: t = 26'sd57;       17: t = 26'sd29;
            18: t = 26'sd14;       19: t = 26'sd7;        20: t = 26'sd4;
            21: t = 26'sd2;        22: t = 26'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ----- src/accel_tilt_angles_unit.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_angles_unit: pitch/roll tilt angles from a 3-axis sample
// Two lanes of square root and CORDIC cells, one per angle, in lockstep.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  s_axis  | in  | tdata: accel_x[13:0], accel_y[27:14], accel_z[41:28]
//  m_axis  | out | tdata: elevation_deg[7:0], rotation_deg[15:8]
//
// One word per clock while the output is not stalled. Registers, in order:
// squares, sum, one per root bit, one per CORDIC stage, then the output.
// The whole chain advances as one shift line: it moves whenever the output
// slot is empty or being taken, so a stalled master holds every stage.
// Reset clears the valid bits only; payload registers are not reset.
module accel_tilt_angles_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ata_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,   // accel_x, accel_y, accel_z, pad
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata    // elevation_deg, rotation_deg
);
    import ata_pkg::*;

    localparam int DEPTH = RUN_STAGES + ROOT_BITS + 3;

    sample_t ax, ay, az;
    assign ax = s_axis_tdata[SAMPLE_BITS-1:0];
    assign ay = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign az = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic [DEPTH-1:0] en;

    // chain moves when the last slot is free or draining
    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign en            = {DEPTH{adv}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    deg_t elev, rot;

    ata_angle_lane u_elev
    (
        .clk(clk), .en(en), .num(az), .a(ax), .b(ay), .deg(elev)
    );

    ata_angle_lane u_rot
    (
        .clk(clk), .en(en), .num(ax), .a(ay), .b(az), .deg(rot)
    );

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {rot, elev};

    logic unused_pad;
    assign unused_pad = ^(s_axis_tdata >> IN_BITS);
endmodule

// ----- src/ata_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// ata_sqrt_cell: one step of the restoring square root
// Resolves one root bit per cycle while en is high and hands the partial state onward.
// ----------------------------------------------------------------------------
module ata_sqrt_cell
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [ata_pkg::RAD_BITS-1:0]     rem_in,
    input  logic [ata_pkg::ROOT_BITS-1:0]    root_in,
    input  logic [ata_pkg::RAD_BITS-1:0]     rad_in,
    output logic [ata_pkg::RAD_BITS-1:0]     rem_out,
    output logic [ata_pkg::ROOT_BITS-1:0]    root_out,
    output logic [ata_pkg::RAD_BITS-1:0]     rad_out
);
    import ata_pkg::*;

    logic [RAD_BITS+1:0]  rem_sh;
    logic [RAD_BITS+1:0]  trial;
    logic [RAD_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_next;

    // bring down next two radicand bits, try (root<<2)|1
    always_comb
    begin
        rem_sh = {rem_in, rad_in[RAD_BITS-1 -: 2]};
        trial  = (RAD_BITS+2)'({root_in, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = RAD_BITS'(rem_sh - trial);
            root_next = {root_in[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = RAD_BITS'(rem_sh);
            root_next = {root_in[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            root_out <= root_next;
            rad_out  <= {rad_in[RAD_BITS-3:0], 2'b00};
        end
    end
endmodule

// ----- src/ata_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// ata_cordic_cell: one vectoring CORDIC rotation
// Shift-add micro-rotation toward y = 0, angle accumulated in Q16 degrees.
// ----------------------------------------------------------------------------
module ata_cordic_cell
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [4:0]                        stage,   // tied to the cell's position
    input  logic signed [ata_pkg::CW-1:0]     x_in,
    input  logic signed [ata_pkg::CW-1:0]     y_in,
    input  logic signed [ata_pkg::ZW-1:0]     z_in,
    output logic signed [ata_pkg::CW-1:0]     x_out,
    output logic signed [ata_pkg::CW-1:0]     y_out,
    output logic signed [ata_pkg::ZW-1:0]     z_out
);
    import ata_pkg::*;

    logic signed [ZW-1:0] t_step;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign t_step = atan_q16(int'(stage));
    assign xs     = x_in >>> stage;
    assign ys     = y_in >>> stage;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[CW-1])
            begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + t_step;
            end
            else
            begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - t_step;
            end
        end
    end
endmodule

// ----- src/ata_angle_lane.sv -----
// ----------------------------------------------------------------------------
// ata_angle_lane: one tilt angle
// Squares, a chain of square root cells, a chain of CORDIC cells, then
// truncation and saturation to whole degrees (+-90 or 0 when a = b = 0).
// ----------------------------------------------------------------------------
module ata_angle_lane
(
    input  logic                      clk,
    input  logic [ata_pkg::RUN_STAGES+ata_pkg::ROOT_BITS+2:0] en,
    input  ata_pkg::sample_t          num,
    input  ata_pkg::sample_t          a,
    input  ata_pkg::sample_t          b,
    output ata_pkg::deg_t             deg
);
    import ata_pkg::*;

    localparam int NS = ROOT_BITS;
    localparam int NC = RUN_STAGES;

    // stage 0: squares
    logic signed [2*SAMPLE_BITS-1:0] aa_reg, bb_reg;
    logic signed [SAMPLE_BITS:0]     n0_reg;
    // stage 1: sum
    logic [SQ_BITS-1:0]              sq_reg;
    logic signed [SAMPLE_BITS:0]     n1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            aa_reg <= a * a;
            bb_reg <= b * b;
            n0_reg <= -(SAMPLE_BITS+1)'(num);
        end
        if (en[1])
        begin
            sq_reg <= SQ_BITS'(aa_reg) + SQ_BITS'(bb_reg);
            n1_reg <= n0_reg;
        end
    end

    logic [RAD_BITS-1:0]  rem_w  [NS+1];
    logic [ROOT_BITS-1:0] root_w [NS+1];
    logic [RAD_BITS-1:0]  rad_w  [NS+1];
    logic signed [SAMPLE_BITS:0] n_w [NS+1];
    logic zero_w [NS+1];

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = {sq_reg, 32'd0};
    assign n_w[0]    = n1_reg;
    assign zero_w[0] = (sq_reg == '0);

    for (genvar i = 0; i < NS; i++)
    begin : g_sq
        ata_sqrt_cell u_cell
        (
            .clk(clk), .en(en[2+i]),
            .rem_in(rem_w[i]), .root_in(root_w[i]), .rad_in(rad_w[i]),
            .rem_out(rem_w[i+1]), .root_out(root_w[i+1]), .rad_out(rad_w[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en[2+i])
            begin
                n_w[i+1]    <= n_w[i];
                zero_w[i+1] <= zero_w[i];
            end
        end
    end

    logic signed [CW-1:0] x_w [NC+1];
    logic signed [CW-1:0] y_w [NC+1];
    logic signed [ZW-1:0] z_w [NC+1];
    spec_t sp_w [NC+1];

    assign x_w[0] = CW'(signed'({1'b0, root_w[NS]}));
    assign y_w[0] = CW'(signed'({n_w[NS], {FRAC_BITS{1'b0}}}));
    assign z_w[0] = '0;
    always_comb
    begin
        if (!zero_w[NS])
            sp_w[0] = SPEC_NONE;
        else if (n_w[NS] == '0)
            sp_w[0] = SPEC_ZERO;
        else if (n_w[NS][SAMPLE_BITS])
            sp_w[0] = SPEC_NEG;
        else
            sp_w[0] = SPEC_POS;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cd
        ata_cordic_cell u_cell
        (
            .clk(clk), .en(en[2+NS+k]), .stage(5'(k)),
            .x_in(x_w[k]), .y_in(y_w[k]), .z_in(z_w[k]),
            .x_out(x_w[k+1]), .y_out(y_w[k+1]), .z_out(z_w[k+1])
        );
        always_ff @(posedge clk)
        begin
            if (en[2+NS+k])
                sp_w[k+1] <= sp_w[k];
        end
    end

    // truncate toward zero, saturate
    logic signed [ZW-1:0] zabs;
    logic signed [ZW-1:0] zt;
    deg_t                 d_next;

    always_comb
    begin
        zabs = z_w[NC][ZW-1] ? -z_w[NC] : z_w[NC];
        zt   = zabs >>> FRAC_BITS;
        if (z_w[NC][ZW-1])
            zt = -zt;
        if (zt > ZW'(HALF_TURN / 2))
            d_next = DEG_MAX;
        else if (zt < -ZW'(HALF_TURN / 2))
            d_next = DEG_MIN;
        else
            d_next = DEG_BITS'(zt);
        unique case (sp_w[NC])
            SPEC_POS:  d_next = DEG_MAX;
            SPEC_NEG:  d_next = DEG_MIN;
            SPEC_ZERO: d_next = '0;
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2+NS+NC])
            deg <= d_next;
    end
endmodule
